// ===== hdl/hnat_pkg.sv =====
// Types and constants shared by the hello neighbor aging table modules.
`default_nettype none

package hnat_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SEQ_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COUNT_OUT_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS = 8'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 32'd0;

    // Input operation codes.
    localparam logic OP_HELLO = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Event codes of a result.
    localparam logic [2:0] EV_DISCOVERED = 3'd0;
    localparam logic [2:0] EV_UPDATED = 3'd1;
    localparam logic [2:0] EV_STALE = 3'd2;
    localparam logic [2:0] EV_FULL = 3'd3;
    localparam logic [2:0] EV_OWN = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;

    // A sweep stops after this many removals.
    localparam logic [4:0] RESULT_LIMIT = 5'd16;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] neighbor_address;
        logic [SEQ_W-1:0]  sequence_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             event_res;
        logic [ADDR_W-1:0]      reported_address;
        logic [SEQ_W-1:0]       reported_sequence;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_HELLO = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_OWN   = 2'd2
    } cmd_kind_e;

    typedef struct packed {
        cmd_kind_e         kind;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] heard_time;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/hnat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hnat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hnat_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none

module hnat_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire hnat_pkg::in_item_t       in_data,
    input  wire logic [hnat_pkg::ADDR_W-1:0] own_address,
    output logic                          cmd_valid,
    input  wire logic                     cmd_ready,
    output hnat_pkg::cmd_t                cmd
);

    import hnat_pkg::*;

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    always_comb
    begin
        new_cmd.addr = in_data.neighbor_address;
        new_cmd.seq = in_data.sequence_number;
        if (in_data.operation == OP_TICK)
        begin
            new_cmd.kind = CMD_TICK;
        end
        else if (in_data.neighbor_address == own_address)
        begin
            new_cmd.kind = CMD_OWN;
        end
        else
        begin
            new_cmd.kind = CMD_HELLO;
        end
    end

    assign in_ready = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd = queue_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hnat_back.sv =====
// Back end: walks the neighbor table in RAM for each command and drives results.
`default_nettype none

module hnat_back #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire hnat_pkg::cmd_t              cmd,
    input  wire logic [hnat_pkg::TIMEOUT_W-1:0] timeout_seconds,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output hnat_pkg::out_item_t              out_data
);

    import hnat_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_MISS   = 7'b0000100,
        S_EMIT   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_MOVE   = 7'b0100000,
        S_END    = 7'b1000000
    } state_e;

    state_e            state_reg;
    state_e            state_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [4:0]        nrem_reg;
    logic [4:0]        nrem_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    out_item_t         pend_reg;
    out_item_t         pend_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    out_item_t         res_reg;
    out_item_t         res_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic              out_free;
    logic              out_load;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    entry_t            rd_data;
    logic [TIME_W-1:0] age;
    logic              expired;
    logic [CW-1:0]     idx_plus1;
    logic [CW-1:0]     count_minus1;

    hnat_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign age = time_reg - rd_data.heard_time;
    assign expired = age > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_seconds};
    assign idx_plus1 = CW'(idx_reg) + CW'(1);
    assign count_minus1 = count_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        time_next = time_reg;
        nrem_next = nrem_reg;
        pend_valid_next = pend_valid_reg;
        pend_next = pend_reg;
        cmd_next = cmd_reg;
        res_next = res_reg;
        cmd_ready = 1'b0;
        out_load = 1'b0;
        out_data_next = res_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data;
        rd_en = 1'b0;
        rd_addr = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        CMD_OWN:
                        begin
                            res_next = '{EV_OWN, cmd.addr, '0, COUNT_OUT_W'(count_reg), 1'b1};
                            state_next = S_EMIT;
                        end
                        CMD_HELLO:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_MISS;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_TICK:
                        begin
                            time_next = time_reg + TIME_W'(1);
                            idx_next = '0;
                            nrem_next = '0;
                            pend_valid_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                rd_en = 1'b1;
                                rd_addr = '0;
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (rd_data.addr == cmd_reg.addr)
                begin
                    if (cmd_reg.seq > rd_data.seq)
                    begin
                        wr_en = 1'b1;
                        wr_data = '{cmd_reg.addr, cmd_reg.seq, time_reg};
                        res_next = '{EV_UPDATED, cmd_reg.addr, cmd_reg.seq,
                                     COUNT_OUT_W'(count_reg), 1'b1};
                    end
                    else
                    begin
                        res_next = '{EV_STALE, cmd_reg.addr, rd_data.seq,
                                     COUNT_OUT_W'(count_reg), 1'b1};
                    end
                    state_next = S_EMIT;
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next = idx_plus1[IW-1:0];
                    rd_en = 1'b1;
                    rd_addr = idx_plus1[IW-1:0];
                end
            end

            S_MISS:
            begin
                if (count_reg == DEPTH_C)
                begin
                    res_next = '{EV_FULL, cmd_reg.addr, '0, COUNT_OUT_W'(count_reg), 1'b1};
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = count_reg[IW-1:0];
                    wr_data = '{cmd_reg.addr, cmd_reg.seq, time_reg};
                    count_next = count_reg + CW'(1);
                    res_next = '{EV_DISCOVERED, cmd_reg.addr, cmd_reg.seq,
                                 COUNT_OUT_W'(count_reg + CW'(1)), 1'b1};
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_data_next = res_reg;
                    state_next = S_IDLE;
                end
            end

            S_CHECK:
            begin
                if (expired)
                begin
                    // A removal flushes the previous one, now known not to be the last.
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_data_next = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next = '{EV_TIMEOUT, rd_data.addr, rd_data.seq,
                                      COUNT_OUT_W'(count_minus1), 1'b0};
                        count_next = count_minus1;
                        nrem_next = nrem_reg + 5'd1;
                        if (count_minus1 == CW'(idx_reg))
                        begin
                            state_next = S_END;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                            rd_addr = count_minus1[IW-1:0];
                            state_next = S_MOVE;
                        end
                    end
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = S_END;
                end
                else
                begin
                    idx_next = idx_plus1[IW-1:0];
                    rd_en = 1'b1;
                    rd_addr = idx_plus1[IW-1:0];
                end
            end

            S_MOVE:
            begin
                // The last entry fills the hole; the read data then stands for this slot.
                wr_en = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                state_next = (nrem_reg == RESULT_LIMIT) ? S_END : S_CHECK;
            end

            S_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    out_data_next = pend_reg;
                    out_data_next.last_of_run = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            time_reg <= '0;
            nrem_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            time_reg <= time_next;
            nrem_reg <= nrem_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/hello_neighbor_aging_table_top.sv =====
// Top level of the hello neighbor aging table: configuration registers and the two halves.
//
// Usage: the in channel (in_valid/in_ready/in_data) carries hello and tick beats. A hello
// gives exactly one result beat; a tick advances the seconds counter and gives one beat
// per neighbor that timed out (at most RESULT_LIMIT), possibly none. The last beat of
// each item has last_of_run set. Results leave on out_valid/out_ready/out_data from an
// output register. Configuration writes (cfg_valid/cfg_index/cfg_data) are always taken
// (cfg_ready is tied high) and must only be issued while no item is in flight.
// With an idle back end, a hello reads the table RAM one entry a cycle until the neighbor
// is found or all entries are read, and a tick examines the entries in turn, each removal
// moving the last entry into the freed slot. Items run one at a time in the back end; a
// two-entry command queue lets the front accept up to two more meanwhile.
// Reset empties the table and clears the seconds counter; the timeout returns to 10 and
// the own address to 0. The table RAM is not cleared: only entries below the count are
// read. When the receiver stalls, the sweep holds, and input stalls once the queue fills.
`default_nettype none

module hello_neighbor_aging_table_top #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire hnat_pkg::in_item_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output hnat_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hnat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hnat_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import hnat_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIMEOUT_W-1:0] timeout_next;
    logic [ADDR_W-1:0]    own_reg;
    logic [ADDR_W-1:0]    own_next;
    logic                 cmd_valid;
    logic                 cmd_ready;
    cmd_t                 cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        timeout_next = timeout_reg;
        own_next = own_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:     timeout_next = cfg_data[TIMEOUT_W-1:0];
                REG_OWN_ADDRESS: own_next = cfg_data[ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            own_reg <= OWN_ADDRESS_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
            own_reg <= own_next;
        end
    end

    hnat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .own_address (own_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    hnat_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .timeout_seconds (timeout_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data)
    );

endmodule

`default_nettype wire
